### rtl/core/tone_step_sequencer_unit_defines.svh
// Assertion macros for the tone step sequencer.
// Used by rtl/core/tone_step_sequencer_unit.sv; needs clk_i and rst_ni in scope.
`ifndef TONE_STEP_SEQUENCER_UNIT_DEFINES_SVH
`define TONE_STEP_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tone step sequencer check failed");

// Next-cycle implication, checked out of reset.
`define TSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tone step sequencer check failed");

`endif

### rtl/core/tss_pkg.sv
// Package for the tone step sequencer: field widths, sizes, command codes
// and the duration saturation helper. No dependencies.
`timescale 1ns / 1ps

package tss_pkg;

  localparam int unsigned STEP_DEPTH = 16;
  localparam int unsigned TIME_BITS  = 16;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned STEP_W  = 4;

  localparam int unsigned POS_W   = (STEP_DEPTH > 1) ? $clog2(STEP_DEPTH) : 1;
  localparam int unsigned TOTAL_W = $clog2(STEP_DEPTH + 1);
  localparam int unsigned CMP_W   = TOTAL_W + 1;

  localparam logic [32:0] TIME_MAX = (33'd1 << TIME_BITS) - 33'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TIMER_TICK = 3'd0,
    CMD_MS_TICK    = 3'd1,
    CMD_PLAY_TONE  = 3'd2,
    CMD_WRITE_STEP = 3'd3,
    CMD_START_SEQ  = 3'd4
  } tss_cmd_e;

  // Clamp a millisecond field to the duration counter range.
  function automatic logic [TIME_BITS-1:0] sat_time(input logic [LEN_W-1:0] v);
    logic [32:0] wide;
    wide = 33'(v);
    if (wide > TIME_MAX) return '1;
    return TIME_BITS'(wide);
  endfunction

endpackage

### rtl/core/tone_step_sequencer_unit.sv
// Tone step sequencer: square-wave buzzer tones and stored step sequences.
// Depends on tss_pkg and tone_step_sequencer_unit_defines.svh.
`timescale 1ns / 1ps
`include "tone_step_sequencer_unit_defines.svh"

// Usage:
//   The input channel (in_valid_i / in_ready_o) carries one command beat:
//   timer tick, millisecond tick, play single tone, write step or start
//   sequence. Every beat produces exactly one status beat on the output
//   channel (out_valid_o / out_ready_i): pin level, tone flag, sequence
//   flag and current step index, all taken after the command is applied.
//   An accepted beat is captured in the input register, then applied to
//   the tone state as its status is written to the result register, once
//   that register is empty or being taken. Throughput is one beat per
//   cycle while the receiver takes status beats; each command needs only
//   counter compares and one read of the 16-entry step store, taken when
//   the beat is captured so that the step it may start is ready.
//   Reset clears the tone and sequence state and leaves both channels
//   empty; the step store is not cleared and must be written before use.
//   When the receiver stalls, the result register holds, the input
//   register fills, and in_ready_o drops until the status beat is taken.
module tone_step_sequencer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tss_pkg::CMD_W-1:0]    command_i,
  input  logic [tss_pkg::SLOT_W-1:0]   step_slot_i,
  input  logic [tss_pkg::HALF_W-1:0]   half_period_i,
  input  logic [tss_pkg::LEN_W-1:0]    tone_length_i,
  input  logic [tss_pkg::LEN_W-1:0]    pause_length_i,
  input  logic [tss_pkg::COUNT_W-1:0]  sequence_length_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         pin_level_o,
  output logic                         tone_on_o,
  output logic                         sequence_busy_o,
  output logic [tss_pkg::STEP_W-1:0]   step_now_o
);
  import tss_pkg::*;

  // input register
  logic                 in_valid_q;
  logic [CMD_W-1:0]     cmd_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [HALF_W-1:0]    half_q;
  logic [LEN_W-1:0]     len_q;
  logic [LEN_W-1:0]     gap_q;
  logic [COUNT_W-1:0]   count_q;
  logic [HALF_W-1:0]    rd_per_q;
  logic [LEN_W-1:0]     rd_len_q;
  logic [LEN_W-1:0]     rd_gap_q;

  // result register
  logic                 out_valid_q;
  logic                 pin_q;
  logic                 tone_q;
  logic                 busy_q;
  logic [STEP_W-1:0]    step_q;

  // tone and sequence state
  logic                 level_q, level_d;
  logic                 sounding_q, sounding_d;
  logic [HALF_W-1:0]    toggle_cnt_q, toggle_cnt_d;
  logic [HALF_W-1:0]    toggle_lim_q, toggle_lim_d;
  logic [TIME_BITS-1:0] time_left_q, time_left_d;
  logic [TIME_BITS-1:0] pause_after_q, pause_after_d;
  logic                 seq_active_q, seq_active_d;
  logic                 in_pause_q, in_pause_d;
  logic [TIME_BITS-1:0] pause_left_q, pause_left_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [TOTAL_W-1:0]   total_q, total_d;

  // step store, undefined until written
  logic [HALF_W-1:0]    per_mem [STEP_DEPTH];
  logic [LEN_W-1:0]     len_mem [STEP_DEPTH];
  logic [LEN_W-1:0]     gap_mem [STEP_DEPTH];

  logic                 process;
  logic [POS_W-1:0]     pos_inc;
  logic [POS_W-1:0]     pos_now;
  logic [POS_W-1:0]     rd_idx;
  logic                 rd_fwd;
  logic                 last_step;
  logic                 store_we;
  logic [HALF_W:0]      toggle_inc;
  logic [TIME_BITS-1:0] time_dec;
  logic [TIME_BITS-1:0] pause_dec;

  logic                 begin_req;
  logic [HALF_W-1:0]    begin_per;
  logic [LEN_W-1:0]     begin_len;
  logic [LEN_W-1:0]     begin_gap;

  assign process    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || process;

  assign pos_inc    = pos_q + POS_W'(1);
  assign last_step  = (CMP_W'(pos_q) + CMP_W'(1)) >= CMP_W'(total_q);
  // position the incoming beat will see once the beat ahead of it is applied
  assign pos_now    = process ? pos_d : pos_q;
  assign rd_idx     = (command_i == CMD_START_SEQ) ? '0 : pos_now + POS_W'(1);
  assign store_we   = process && (cmd_q == CMD_WRITE_STEP) && (32'(slot_q) < STEP_DEPTH);
  assign rd_fwd     = store_we && (POS_W'(slot_q) == rd_idx);
  assign toggle_inc = {1'b0, toggle_cnt_q} + (HALF_W + 1)'(1);
  assign time_dec   = (time_left_q != '0) ? time_left_q - TIME_BITS'(1) : time_left_q;
  assign pause_dec  = (pause_left_q != '0) ? pause_left_q - TIME_BITS'(1) : pause_left_q;

  always_comb begin
    level_d       = level_q;
    sounding_d    = sounding_q;
    toggle_cnt_d  = toggle_cnt_q;
    toggle_lim_d  = toggle_lim_q;
    time_left_d   = time_left_q;
    pause_after_d = pause_after_q;
    seq_active_d  = seq_active_q;
    in_pause_d    = in_pause_q;
    pause_left_d  = pause_left_q;
    pos_d         = pos_q;
    total_d       = total_q;
    begin_req     = 1'b0;
    begin_per     = rd_per_q;
    begin_len     = rd_len_q;
    begin_gap     = rd_gap_q;

    case (cmd_q)
      CMD_TIMER_TICK: begin
        if (sounding_q) begin
          if (toggle_inc >= {1'b0, toggle_lim_q}) begin
            level_d      = !level_q;
            toggle_cnt_d = '0;
          end else begin
            toggle_cnt_d = toggle_inc[HALF_W-1:0];
          end
        end
      end
      CMD_MS_TICK: begin
        if (sounding_q) begin
          time_left_d = time_dec;
          if (time_dec == '0) begin
            // tone over: silence, then gap, advance or end a running sequence
            sounding_d    = 1'b0;
            level_d       = 1'b0;
            toggle_cnt_d  = '0;
            time_left_d   = '0;
            pause_after_d = '0;
            if (seq_active_q) begin
              if (pause_after_q != '0) begin
                in_pause_d   = 1'b1;
                pause_left_d = pause_after_q;
              end else if (last_step) begin
                seq_active_d = 1'b0;
                in_pause_d   = 1'b0;
              end else begin
                pos_d     = pos_inc;
                begin_req = 1'b1;
              end
            end
          end
        end else if (seq_active_q && in_pause_q) begin
          pause_left_d = pause_dec;
          if (pause_dec == '0) begin
            in_pause_d = 1'b0;
            if (last_step) begin
              seq_active_d = 1'b0;
            end else begin
              pos_d     = pos_inc;
              begin_req = 1'b1;
            end
          end
        end
      end
      CMD_PLAY_TONE: begin
        seq_active_d = 1'b0;
        in_pause_d   = 1'b0;
        pause_left_d = '0;
        begin_req    = 1'b1;
        begin_per    = half_q;
        begin_len    = len_q;
        begin_gap    = '0;
      end
      CMD_START_SEQ: begin
        if (count_q != '0) begin
          sounding_d    = 1'b0;
          level_d       = 1'b0;
          toggle_cnt_d  = '0;
          time_left_d   = '0;
          pause_after_d = '0;
          total_d       = (32'(count_q) > STEP_DEPTH) ? TOTAL_W'(STEP_DEPTH)
                                                       : TOTAL_W'(count_q);
          pos_d         = '0;
          seq_active_d  = 1'b1;
          in_pause_d    = 1'b0;
          pause_left_d  = '0;
          begin_req     = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (begin_req) begin
      if (begin_per == '0 || begin_len == '0) begin
        // empty step: stop the tone and drop the sequence
        sounding_d    = 1'b0;
        level_d       = 1'b0;
        toggle_cnt_d  = '0;
        time_left_d   = '0;
        pause_after_d = '0;
        seq_active_d  = 1'b0;
        in_pause_d    = 1'b0;
      end else begin
        level_d       = 1'b0;
        toggle_cnt_d  = '0;
        toggle_lim_d  = begin_per;
        time_left_d   = sat_time(begin_len);
        pause_after_d = sat_time(begin_gap);
        sounding_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q   <= command_i;
      slot_q  <= step_slot_i;
      half_q  <= half_period_i;
      len_q   <= tone_length_i;
      gap_q   <= pause_length_i;
      count_q <= sequence_length_i;
      // fetch the step this beat may start; take a write landing on it now
      if (rd_fwd) begin
        rd_per_q <= half_q;
        rd_len_q <= len_q;
        rd_gap_q <= gap_q;
      end else begin
        rd_per_q <= per_mem[rd_idx];
        rd_len_q <= len_mem[rd_idx];
        rd_gap_q <= gap_mem[rd_idx];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      per_mem[POS_W'(slot_q)] <= half_q;
      len_mem[POS_W'(slot_q)] <= len_q;
      gap_mem[POS_W'(slot_q)] <= gap_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q       <= 1'b0;
      sounding_q    <= 1'b0;
      toggle_cnt_q  <= '0;
      toggle_lim_q  <= '0;
      time_left_q   <= '0;
      pause_after_q <= '0;
      seq_active_q  <= 1'b0;
      in_pause_q    <= 1'b0;
      pause_left_q  <= '0;
      pos_q         <= '0;
      total_q       <= '0;
    end else if (process) begin
      level_q       <= level_d;
      sounding_q    <= sounding_d;
      toggle_cnt_q  <= toggle_cnt_d;
      toggle_lim_q  <= toggle_lim_d;
      time_left_q   <= time_left_d;
      pause_after_q <= pause_after_d;
      seq_active_q  <= seq_active_d;
      in_pause_q    <= in_pause_d;
      pause_left_q  <= pause_left_d;
      pos_q         <= pos_d;
      total_q       <= total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (process) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      pin_q  <= level_d;
      tone_q <= sounding_d;
      busy_q <= seq_active_d;
      step_q <= STEP_W'(pos_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pin_level_o     = pin_q;
  assign tone_on_o       = tone_q;
  assign sequence_busy_o = busy_q;
  assign step_now_o      = step_q;

  `TSS_ASSERT_NOW(a_sound_has_period, sounding_q, toggle_lim_q != '0)
  `TSS_ASSERT_NOW(a_sound_has_time, sounding_q, time_left_q != '0)
  `TSS_ASSERT_NOW(a_pause_silent, in_pause_q, seq_active_q && !sounding_q)
  `TSS_ASSERT_NOW(a_pos_in_range, seq_active_q, CMP_W'(pos_q) < CMP_W'(total_q))
  `TSS_ASSERT_NEXT(a_beat_yields_result, process, out_valid_q)

endmodule

### dv/buzzer_status_sb_pkg.sv
// Status scoreboard for the tone step sequencer testbench: a cycle-free model
// of the tone, gap and step state and a queue of the status beats it predicts.
// Depends on tss_pkg for widths, sizes and command codes.
`timescale 1ns / 1ps

package buzzer_status_sb_pkg;
  import tss_pkg::*;

  typedef struct packed {
    logic              pin_level;
    logic              tone_on;
    logic              sequence_busy;
    logic [STEP_W-1:0] step_now;
  } buzzer_status_t;

  class buzzer_status_scoreboard;
    buzzer_status_t     status_queue[$];
    int                 mismatch_count;
    int                 checked_beats;

    logic                 pin_state;
    logic                 sounding;
    logic [HALF_W-1:0]    toggle_count;
    logic [HALF_W-1:0]    toggle_limit;
    logic [TIME_BITS-1:0] ms_left;
    logic [TIME_BITS-1:0] gap_after;
    logic                 seq_running;
    logic                 in_gap;
    logic [TIME_BITS-1:0] gap_left;
    logic [POS_W-1:0]     step_index;
    logic [TOTAL_W-1:0]   step_count;
    logic [HALF_W-1:0]    step_period[STEP_DEPTH];
    logic [LEN_W-1:0]     step_length[STEP_DEPTH];
    logic [LEN_W-1:0]     step_gap[STEP_DEPTH];

    function new();
      mismatch_count = 0;
      checked_beats  = 0;
      pin_state      = 1'b0;
      sounding       = 1'b0;
      toggle_count   = '0;
      toggle_limit   = '0;
      ms_left        = '0;
      gap_after      = '0;
      seq_running    = 1'b0;
      in_gap         = 1'b0;
      gap_left       = '0;
      step_index     = '0;
      step_count     = '0;
      for (int i = 0; i < STEP_DEPTH; i++) begin
        step_period[i] = '0;
        step_length[i] = '0;
        step_gap[i]    = '0;
      end
    endfunction

    function int pending();
      return status_queue.size();
    endfunction

    function void report_mismatch(string msg);
      mismatch_count++;
      $display("MISMATCH at status beat %0d: %s", checked_beats, msg);
    endfunction

    // Clamp a millisecond field to the duration counter range.
    function logic [TIME_BITS-1:0] clamp_ms(logic [LEN_W-1:0] v);
      if (LEN_W > TIME_BITS && (v >> TIME_BITS) != 0) return '1;
      return TIME_BITS'(v);
    endfunction

    function void silence_tone();
      sounding     = 1'b0;
      pin_state    = 1'b0;
      toggle_count = '0;
      ms_left      = '0;
      gap_after    = '0;
    endfunction

    function void sound_tone(logic [HALF_W-1:0] period, logic [LEN_W-1:0] length,
                             logic [LEN_W-1:0] gap);
      // A zero period or zero duration stops everything, sequence included.
      if (period == '0 || length == '0) begin
        silence_tone();
        seq_running = 1'b0;
        in_gap      = 1'b0;
        return;
      end
      pin_state    = 1'b0;
      toggle_count = '0;
      toggle_limit = period;
      ms_left      = clamp_ms(length);
      gap_after    = clamp_ms(gap);
      sounding     = 1'b1;
    endfunction

    function void play_stored_step();
      sound_tone(step_period[step_index], step_length[step_index], step_gap[step_index]);
    endfunction

    function void advance_melody();
      if (!seq_running) return;
      if (int'(step_index) + 1 >= int'(step_count)) begin
        seq_running = 1'b0;
        in_gap      = 1'b0;
        return;
      end
      step_index++;
      play_stored_step();
    endfunction

    // Apply one accepted command beat and queue the status it must produce.
    function void note_command(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                               logic [HALF_W-1:0] half, logic [LEN_W-1:0] length,
                               logic [LEN_W-1:0] gap, logic [COUNT_W-1:0] count);
      logic [TIME_BITS-1:0] held_gap;
      buzzer_status_t       status;
      case (cmd)
        CMD_TIMER_TICK: begin
          if (sounding) begin
            toggle_count++;
            if (toggle_count >= toggle_limit) begin
              pin_state    = ~pin_state;
              toggle_count = '0;
            end
          end
        end
        CMD_MS_TICK: begin
          if (sounding) begin
            if (ms_left > 0) ms_left--;
            if (ms_left == 0) begin
              held_gap = gap_after;
              silence_tone();
              if (seq_running) begin
                if (held_gap == 0) begin
                  advance_melody();
                end else begin
                  in_gap   = 1'b1;
                  gap_left = held_gap;
                end
              end
            end
          end else if (seq_running && in_gap) begin
            if (gap_left > 0) gap_left--;
            if (gap_left == 0) begin
              in_gap = 1'b0;
              advance_melody();
            end
          end
        end
        CMD_PLAY_TONE: begin
          seq_running = 1'b0;
          in_gap      = 1'b0;
          gap_left    = '0;
          sound_tone(half, length, '0);
        end
        CMD_WRITE_STEP: begin
          if (int'(slot) < STEP_DEPTH) begin
            step_period[slot] = half;
            step_length[slot] = length;
            step_gap[slot]    = gap;
          end
        end
        CMD_START_SEQ: begin
          if (count != '0) begin
            silence_tone();
            step_count  = (int'(count) > STEP_DEPTH) ? TOTAL_W'(STEP_DEPTH) : TOTAL_W'(count);
            step_index  = '0;
            seq_running = 1'b1;
            in_gap      = 1'b0;
            gap_left    = '0;
            play_stored_step();
          end
        end
        default: ;
      endcase
      status.pin_level     = pin_state;
      status.tone_on       = sounding;
      status.sequence_busy = seq_running;
      status.step_now      = STEP_W'(step_index);
      status_queue.push_back(status);
    endfunction

    function void check_status(logic pin, logic tone, logic busy, logic [STEP_W-1:0] step);
      buzzer_status_t want;
      if (status_queue.size() == 0) begin
        report_mismatch("status beat with nothing expected");
        return;
      end
      want = status_queue.pop_front();
      if (pin !== want.pin_level)
        report_mismatch($sformatf("pin_level got %b want %b", pin, want.pin_level));
      if (tone !== want.tone_on)
        report_mismatch($sformatf("tone_on got %b want %b", tone, want.tone_on));
      if (busy !== want.sequence_busy)
        report_mismatch($sformatf("sequence_busy got %b want %b", busy, want.sequence_busy));
      if (step !== want.step_now)
        report_mismatch($sformatf("step_now got %0d want %0d", step, want.step_now));
      checked_beats++;
    endfunction
  endclass

endpackage

### dv/tone_step_sequencer_unit_tb.sv
// Top-level testbench for tone_step_sequencer_unit: directed and random
// command beats with random idling on both channels, checked by the status
// scoreboard in buzzer_status_sb_pkg. Depends on tss_pkg.
`timescale 1ns / 1ps

module tone_step_sequencer_unit_tb;
  import tss_pkg::*;
  import buzzer_status_sb_pkg::*;

  localparam int RANDOM_BEATS   = 850;
  localparam int HOLD_OFF_AFTER = 300;
  localparam int HOLD_OFF_LEN   = 400;
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_W'(CMD_START_SEQ + 1);
  localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = '1;

  logic                 clk_i             = 1'b0;
  logic                 rst_ni            = 1'b0;
  logic                 in_valid_i        = 1'b0;
  logic                 in_ready_o;
  logic [CMD_W-1:0]     command_i         = '0;
  logic [SLOT_W-1:0]    step_slot_i       = '0;
  logic [HALF_W-1:0]    half_period_i     = '0;
  logic [LEN_W-1:0]     tone_length_i     = '0;
  logic [LEN_W-1:0]     pause_length_i    = '0;
  logic [COUNT_W-1:0]   sequence_length_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i       = 1'b0;
  logic                 pin_level_o;
  logic                 tone_on_o;
  logic                 sequence_busy_o;
  logic [STEP_W-1:0]    step_now_o;

  buzzer_status_scoreboard sb;
  int  beats_sent  = 0;
  bit  send_burst  = 1'b0;
  bit  take_burst  = 1'b0;

  tone_step_sequencer_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .step_slot_i       (step_slot_i),
    .half_period_i     (half_period_i),
    .tone_length_i     (tone_length_i),
    .pause_length_i    (pause_length_i),
    .sequence_length_i (sequence_length_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .pin_level_o       (pin_level_o),
    .tone_on_o         (tone_on_o),
    .sequence_busy_o   (sequence_busy_o),
    .step_now_o        (step_now_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Sample both channels with pre-edge values; note the input before checking.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.note_command(command_i, step_slot_i, half_period_i, tone_length_i,
                        pause_length_i, sequence_length_i);
      if (out_valid_o && out_ready_i)
        sb.check_status(pin_level_o, tone_on_o, sequence_busy_o, step_now_o);
    end
  end

  task automatic send_command(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                              logic [HALF_W-1:0] half, logic [LEN_W-1:0] length,
                              logic [LEN_W-1:0] gap, logic [COUNT_W-1:0] count);
    int idle;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    idle = send_burst ? 0 : $urandom_range(0, 11);
    if (idle > 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    command_i         <= cmd;
    step_slot_i       <= slot;
    half_period_i     <= half;
    tone_length_i     <= length;
    pause_length_i    <= gap;
    sequence_length_i <= count;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
  endtask

  // Mostly short periods and durations so that tones and gaps end quickly.
  function automatic logic [HALF_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 29);
    if (r == 0) return '0;
    if (r == 1) return HALF_W'($urandom);
    return HALF_W'($urandom_range(1, 5));
  endfunction

  function automatic logic [LEN_W-1:0] pick_ms(int zero_weight);
    int r;
    r = $urandom_range(0, 39);
    if (r < zero_weight) return '0;
    if (r == 39) return LEN_W'($urandom);
    return LEN_W'($urandom_range(1, 4));
  endfunction

  // Any command code, unused ones included.
  function automatic logic [CMD_W-1:0] CMD_WIDTH_ANY();
    return CMD_W'($urandom_range(0, (1 << CMD_W) - 1));
  endfunction

  task automatic write_random_step(logic [SLOT_W-1:0] slot);
    send_command(CMD_WRITE_STEP, slot, pick_period(), pick_ms(1), pick_ms(12),
                 COUNT_W'($urandom));
  endtask

  task automatic run_ticks(int n);
    repeat (n) begin
      send_command($urandom_range(0, 1) ? CMD_MS_TICK : CMD_TIMER_TICK, SLOT_W'($urandom),
                   HALF_W'($urandom), LEN_W'($urandom), LEN_W'($urandom),
                   COUNT_W'($urandom));
    end
  endtask

  // Receiver: random stall per beat, one long hold-off to back up the input.
  initial begin
    int idle;
    int taken;
    bit held_off;
    taken    = 0;
    held_off = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
      idle = take_burst ? 0 : $urandom_range(0, 11);
      if (!held_off && taken >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        idle     = HOLD_OFF_LEN;
      end
      if (idle > 0) begin
        out_ready_i <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int directed_end;
    int pick;
    logic [COUNT_W-1:0] count;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unused codes, ticks while silent, a short tone end to end.
    send_command(CMD_FIRST_UNUSED, '0, '0, '0, '0, '0);
    send_command(CMD_LAST_UNUSED, '1, '1, '1, '1, '1);
    send_command(CMD_TIMER_TICK, '0, '0, '0, '0, '0);
    send_command(CMD_MS_TICK, '0, '0, '0, '0, '0);
    send_command(CMD_PLAY_TONE, '0, 16'd1, 16'd2, 16'd7, '0);
    send_command(CMD_TIMER_TICK, '0, '0, '0, '0, '0);
    send_command(CMD_TIMER_TICK, '0, '0, '0, '0, '0);
    send_command(CMD_MS_TICK, '0, '0, '0, '0, '0);
    send_command(CMD_MS_TICK, '0, '0, '0, '0, '0);
    // Zero period, then zero duration, then the widest tone.
    send_command(CMD_PLAY_TONE, '0, '0, 16'd5, '0, '0);
    send_command(CMD_PLAY_TONE, '0, 16'd3, '0, '0, '0);
    send_command(CMD_PLAY_TONE, '1, '1, '1, '1, '1);
    send_command(CMD_TIMER_TICK, '0, '0, '0, '0, '0);
    // Start with zero length is dropped; the tone keeps sounding.
    send_command(CMD_START_SEQ, '0, '0, '0, '0, '0);
    send_command(CMD_WRITE_STEP, 4'd0, 16'd1, 16'd1, 16'd0, '0);
    send_command(CMD_WRITE_STEP, 4'd1, 16'd2, 16'd1, 16'd2, '0);
    send_command(CMD_WRITE_STEP, 4'd2, 16'd0, 16'd3, 16'd1, '0);
    send_command(CMD_WRITE_STEP, '1, '1, '1, '1, '0);
    // Oversized length saturates; the zero-period step ends the melody early.
    send_command(CMD_START_SEQ, '0, '0, '0, '0, '1);
    send_command(CMD_TIMER_TICK, '0, '0, '0, '0, '0);
    repeat (4) send_command(CMD_MS_TICK, '0, '0, '0, '0, '0);
    send_command(CMD_START_SEQ, '0, '0, '0, '0, 5'd1);
    send_command(CMD_MS_TICK, '0, '0, '0, '0, '0);
    // A single tone cancels a running melody.
    send_command(CMD_START_SEQ, '0, '0, '0, '0, 5'd2);
    send_command(CMD_PLAY_TONE, '0, 16'd2, 16'd1, '0, '0);
    directed_end = beats_sent;

    // Fill every slot before any melody can reach it.
    for (int s = 0; s < STEP_DEPTH; s++) write_random_step(SLOT_W'(s));

    while (beats_sent < directed_end + RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        repeat ($urandom_range(0, 3)) write_random_step(SLOT_W'($urandom_range(0, STEP_DEPTH - 1)));
        if ($urandom_range(0, 9) == 0)
          count = COUNT_W'($urandom_range(STEP_DEPTH, (1 << COUNT_W) - 1));
        else
          count = COUNT_W'($urandom_range(1, 6));
        send_command(CMD_START_SEQ, SLOT_W'($urandom), HALF_W'($urandom), LEN_W'($urandom),
                     LEN_W'($urandom), count);
        run_ticks($urandom_range(10, 40));
      end else if (pick < 75) begin
        send_command(CMD_PLAY_TONE, SLOT_W'($urandom), pick_period(), pick_ms(1),
                     LEN_W'($urandom), COUNT_W'($urandom));
        run_ticks($urandom_range(5, 20));
      end else begin
        repeat ($urandom_range(1, 4))
          send_command(CMD_WIDTH_ANY(), SLOT_W'($urandom), HALF_W'($urandom),
                       LEN_W'($urandom), LEN_W'($urandom), COUNT_W'($urandom));
      end
    end
    in_valid_i <= 1'b0;

    for (int n = 0; n < 5000 && sb.pending() != 0; n++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d status beats never arrived", sb.pending()));
    if (sb.mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/tss_pkg.sv
rtl/core/tone_step_sequencer_unit.sv
dv/buzzer_status_sb_pkg.sv
dv/tone_step_sequencer_unit_tb.sv
